@@ rtl/core/dssf_pkg.sv @@
// Package for the decimal seven-segment formatter.
// Holds the queued item type, the font lookup and the divide-by-ten constants.
// No dependencies.
`default_nettype none

package dssf_pkg;

  localparam int VALUE_W = 32;
  localparam int PAD_W   = 8;
  localparam int CFG_W   = 4;
  localparam int SEG_W   = 8;
  localparam int POS_W   = 3;

  localparam logic [CFG_W-1:0] DIGIT_COUNT_RESET = 4'd8;

  // floor(n / 10) == (n * RECIP) >> RECIP_SHIFT for every 32-bit n
  localparam logic [63:0] RECIP       = 64'h0000_0000_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic [CFG_W-1:0]   digit_count;
    logic [PAD_W-1:0]   pad_pattern;
    logic [VALUE_W-1:0] value;
  } item_t;

  // Font: bit 7 DP, bits 6..0 segments A..G
  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h7E;
      4'd1:    seg = 8'h30;
      4'd2:    seg = 8'h6D;
      4'd3:    seg = 8'h79;
      4'd4:    seg = 8'h33;
      4'd5:    seg = 8'h5B;
      4'd6:    seg = 8'h5F;
      4'd7:    seg = 8'h70;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h7B;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/decimal_seven_segment_formatter.sv @@
// Top level of the decimal seven-segment formatter: digit count register,
// front stage, item queue and digit sequencer. Depends on dssf_pkg,
// dssf_front, dssf_queue and dssf_back.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value[31:0], pad_pattern[39:32]
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: position[2:0], segments[10:3];
//                                                tlast: last
//   cfg       in   cfg_we                        cfg_wdata: digit_count[3:0]
//
// Each number yields min(digit_count, MAX_POSITIONS) output words, one per
// cycle from the digit sequencer's divide-by-ten step while m_axis is not
// stalled. Numbers follow each other back to back when the queue holds the next.
// Input reaches the output register through the front stage, queue and sequencer.
// rst is synchronous and clears the valid, busy and queue state; digit_count resets to 8.
// The input keeps accepting until the front stage and the two-entry queue are full.
`default_nettype none

module decimal_seven_segment_formatter #(
  parameter int MAX_POSITIONS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], pad_pattern[39:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // position[2:0], segments[10:3], zero[15:11]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);

  logic [dssf_pkg::CFG_W-1:0] digit_count;

  logic                       push;
  logic                       push_ready;
  dssf_pkg::item_t            push_item;
  logic                       pop;
  logic                       pop_valid;
  dssf_pkg::item_t            pop_item;
  logic [dssf_pkg::POS_W-1:0] position;
  logic [dssf_pkg::SEG_W-1:0] segments;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= dssf_pkg::DIGIT_COUNT_RESET;
    end else if (cfg_we) begin
      digit_count <= cfg_wdata;
    end
  end

  dssf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_value    (s_axis_tdata[31:0]),
    .in_pad      (s_axis_tdata[39:32]),
    .digit_count (digit_count),
    .push        (push),
    .push_item   (push_item),
    .push_ready  (push_ready)
  );

  dssf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  dssf_back #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_item       (pop_item),
    .q_pop        (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (position),
    .out_segments (segments),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, segments, position};

endmodule

`default_nettype wire

@@ rtl/core/dssf_front.sv @@
// Front stage: accepts input words, snapshots the digit count and drops
// numbers that produce no digits. Depends on dssf_pkg.
`default_nettype none

module dssf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dssf_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [dssf_pkg::PAD_W-1:0]    in_pad,
  input  wire logic [dssf_pkg::CFG_W-1:0]    digit_count,
  output logic                               push,
  output dssf_pkg::item_t                    push_item,
  input  wire logic                          push_ready
);

  logic            stage_valid;
  dssf_pkg::item_t stage_item;
  logic            accept;

  assign in_ready  = !stage_valid || push_ready;
  assign accept    = in_valid && in_ready;
  assign push      = stage_valid && push_ready;
  assign push_item = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      // drop numbers with a zero digit count here
      stage_valid <= (digit_count != '0);
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.value       <= in_value;
      stage_item.pad_pattern <= in_pad;
      stage_item.digit_count <= digit_count;
    end
  end

  a_stage_nonzero: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (stage_item.digit_count != '0))
    else $error("front stage holds a number with zero digit count");

  a_no_push_after_reset: assert property (@(posedge clk)
    rst |=> !stage_valid)
    else $error("front stage valid right after reset");

  a_push_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !push_ready) |-> !in_ready)
    else $error("front accepts while stage is full and queue is stalled");

endmodule

`default_nettype wire

@@ rtl/core/dssf_queue.sv @@
// Two-entry queue between the front stage and the digit sequencer.
// Depends on dssf_pkg.
`default_nettype none

module dssf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dssf_pkg::item_t push_item,
  output logic                 push_ready,
  input  wire logic            pop,
  output dssf_pkg::item_t      pop_item,
  output logic                 pop_valid
);

  localparam int DEPTH = 2;

  dssf_pkg::item_t entries [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign push_ready = (fill != 2'(DEPTH));
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fill != 2'(DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (fill != 2'd0))
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

@@ rtl/core/dssf_back.sv @@
// Digit sequencer: peels one decimal digit per cycle, while the output advances,
// with a reciprocal multiply, maps it through the font and drives the output register.
// Depends on dssf_pkg.
`default_nettype none

module dssf_back #(
  parameter int MAX_POSITIONS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire dssf_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [dssf_pkg::POS_W-1:0]       out_position,
  output logic [dssf_pkg::SEG_W-1:0]       out_segments,
  output logic                             out_last
);

  localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
  localparam int CMP_W = (CNT_W > dssf_pkg::CFG_W) ? CNT_W : dssf_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAX_WIDE = CMP_W'(MAX_POSITIONS);

  logic                         busy;
  logic [dssf_pkg::VALUE_W-1:0] rest;
  logic [dssf_pkg::PAD_W-1:0]   pad;
  logic [CNT_W-1:0]             pos;
  logic [CNT_W-1:0]             cnt;

  logic                         advance;
  logic                         load;
  logic                         is_last;
  logic [CNT_W-1:0]             pos_inc;
  logic [CMP_W-1:0]             dc_wide;
  logic [CNT_W-1:0]             cnt_load;
  logic [63:0]                  prod;
  logic [dssf_pkg::VALUE_W-1:0] quot;
  logic [dssf_pkg::VALUE_W-1:0] ten_quot;
  logic [3:0]                   rem;
  logic [dssf_pkg::SEG_W-1:0]   seg_next;

  assign advance = !out_valid || out_ready;
  assign pos_inc = pos + CNT_W'(1);
  assign is_last = busy && (pos_inc == cnt);
  assign load    = advance && q_valid && (!busy || is_last);
  assign q_pop   = load;

  // saturate the digit count to the number of positions
  assign dc_wide  = CMP_W'(q_item.digit_count);
  assign cnt_load = (dc_wide > MAX_WIDE) ? CNT_W'(MAX_WIDE) : CNT_W'(dc_wide);

  // rest / 10 by reciprocal multiply, remainder by shift-add
  assign prod     = 64'(rest) * dssf_pkg::RECIP;
  assign quot     = dssf_pkg::VALUE_W'(prod >> dssf_pkg::RECIP_SHIFT);
  assign ten_quot = (quot << 3) + (quot << 1);
  assign rem      = 4'(rest - ten_quot);

  always_comb begin
    if (rest != '0) begin
      seg_next = dssf_pkg::glyph(rem);
    end else if (pos == '0) begin
      seg_next = dssf_pkg::glyph(4'd0);
    end else begin
      seg_next = pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= busy;
      if (load) begin
        busy <= 1'b1;
      end else if (is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        out_position <= dssf_pkg::POS_W'(pos);
        out_segments <= seg_next;
        out_last     <= is_last;
      end
      if (load) begin
        rest <= q_item.value;
        pad  <= q_item.pad_pattern;
        pos  <= '0;
        cnt  <= cnt_load;
      end else if (busy) begin
        rest <= quot;
        pos  <= pos_inc;
      end
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos < cnt))
    else $error("digit position past count");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || is_last))
    else $error("load while a number is still in progress");

  a_emit_after_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && advance) |=> out_valid)
    else $error("digit step did not produce an output word");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for decimal_seven_segment_formatter.
// Drives numbers through the input stream, predicts each segment word and checks the output
// stream under random stalls on both sides. Depends on dssf_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DISPLAY_MAX = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 20;

  localparam logic [dssf_pkg::CFG_W-1:0] PHASE_COUNT [PHASES] = '{
    4'd3, 4'd15, 4'd1, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8
  };

  // DP, A..G from bit 7 down
  localparam logic [dssf_pkg::SEG_W-1:0] FONT_LUT [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  typedef struct packed {
    logic [dssf_pkg::PAD_W-1:0]   pad;
    logic [dssf_pkg::VALUE_W-1:0] value;
  } number_t;

  typedef struct {
    logic [dssf_pkg::POS_W-1:0] position;
    logic [dssf_pkg::SEG_W-1:0] segments;
    logic                       last;
  } digit_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // value[31:0], pad_pattern[39:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // position[2:0], segments[10:3], zero[15:11]
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  number_t     number_q[$];
  digit_word_t digit_word_q[$];
  logic [dssf_pkg::CFG_W-1:0] digit_count_shadow = dssf_pkg::DIGIT_COUNT_RESET;
  int unsigned idle_in_pct = 30;
  int unsigned idle_out_pct = 87;
  int unsigned pushed_numbers = 0;
  int unsigned issued_numbers = 0;
  int unsigned accepted_numbers = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  decimal_seven_segment_formatter u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic predict_digits(input logic [dssf_pkg::VALUE_W-1:0] value,
                                input logic [dssf_pkg::PAD_W-1:0] pad);
    logic [dssf_pkg::VALUE_W-1:0] rest;
    int unsigned count;
    digit_word_t w;
    rest = value;
    count = (digit_count_shadow > DISPLAY_MAX) ? DISPLAY_MAX : digit_count_shadow;
    for (int unsigned pos = 0; pos < count; pos++) begin
      if (rest == 0) begin
        w.segments = (pos == 0) ? FONT_LUT[0] : pad;
      end else begin
        w.segments = FONT_LUT[rest % 10];
        rest = rest / 10;
      end
      w.position = pos[dssf_pkg::POS_W-1:0];
      w.last = (pos + 1 == count);
      digit_word_q.push_back(w);
    end
  endtask

  task automatic queue_number(input logic [dssf_pkg::VALUE_W-1:0] value,
                              input logic [dssf_pkg::PAD_W-1:0] pad);
    number_t n;
    n.value = value;
    n.pad = pad;
    number_q.push_back(n);
    pushed_numbers++;
  endtask

  // Hold until every number is taken and every digit word has arrived, then drain.
  task automatic wait_idle();
    while (accepted_numbers != pushed_numbers || digit_word_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_digit_count(input logic [dssf_pkg::CFG_W-1:0] count);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    digit_count_shadow = count;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [dssf_pkg::VALUE_W-1:0] pick_value();
    logic [dssf_pkg::VALUE_W-1:0] p;
    p = 1;
    case ($urandom_range(3))
      0: return $urandom_range(9999);
      1: return $urandom;
      2: begin
        repeat ($urandom_range(9)) p = p * 10;
        return p - $urandom_range(1);
      end
      default: return $urandom_range(99);
    endcase
  endfunction

  // Sender: hold the word until taken, then load the next one or idle.
  always @(negedge clk) begin
    number_t nxt;
    logic    taken;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      taken = s_axis_tvalid && (accepted_numbers == issued_numbers);
      if (!s_axis_tvalid || taken) begin
        if (number_q.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
          nxt = number_q.pop_front();
          issued_numbers++;
          s_axis_tdata <= nxt;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_out_pct);
  end

  // Monitor: predict on input words, check output words against the oldest expectation.
  always @(posedge clk) begin
    digit_word_t w;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata[31:0], s_axis_tdata[39:32]);
        accepted_numbers <= accepted_numbers + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (digit_word_q.size() == 0) begin
          $display("%0t: unexpected digit word tdata=%h tlast=%b", $time, m_axis_tdata,
                   m_axis_tlast);
          mismatches++;
        end else begin
          w = digit_word_q.pop_front();
          if (m_axis_tdata[2:0] !== w.position) begin
            $display("%0t: position mismatch expected %0d actual %0d", $time, w.position,
                     m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[10:3] !== w.segments) begin
            $display("%0t: segments mismatch at position %0d expected %h actual %h", $time,
                     w.position, w.segments, m_axis_tdata[10:3]);
            mismatches++;
          end
          if (m_axis_tlast !== w.last) begin
            $display("%0t: last mismatch at position %0d expected %b actual %b", $time,
                     w.position, w.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of eight: blanking, zero, boundaries and dropped high digits
    queue_number(32'd0, 8'h00);
    queue_number(32'd0, 8'hFF);
    queue_number(32'd1, 8'hA5);
    queue_number(32'd9, 8'h5A);
    queue_number(32'd10, 8'h80);
    queue_number(32'd12345678, 8'h5A);
    queue_number(32'd99999999, 8'h01);
    queue_number(32'd100000000, 8'h00);
    queue_number(32'hFFFF_FFFF, 8'hFF);
    queue_number(32'd4000000000, 8'h7F);
    wait_idle();

    // counts above the maximum saturate, then a count of one
    write_digit_count(4'd15);
    queue_number(32'd7, 8'hC3);
    queue_number(32'hFFFF_FFFF, 8'h3C);
    wait_idle();
    write_digit_count(4'd9);
    queue_number(32'd123, 8'h00);
    wait_idle();
    write_digit_count(4'd1);
    queue_number(32'd0, 8'hFF);
    queue_number(32'd5, 8'h00);
    queue_number(32'hFFFF_FFFF, 8'hAA);
    wait_idle();

    // zero count gives no words at all
    write_digit_count(4'd0);
    queue_number(32'd42, 8'h11);
    queue_number(32'd0, 8'h22);
    queue_number(32'hFFFF_FFFF, 8'h33);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PHASES / 3) begin
        idle_in_pct = 30;
        idle_out_pct = 87;
      end else if (ph < 2 * PHASES / 3) begin
        idle_in_pct = 87;
        idle_out_pct = 30;
      end else begin
        idle_in_pct = 0;
        idle_out_pct = 0;
      end
      write_digit_count(PHASE_COUNT[ph]);
      repeat (ITEMS_PER_PHASE) queue_number(pick_value(), $urandom_range(255));
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
